@@ hdl/tlsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsq_pkg: shared types and constants for the four-way traffic sequencer
// Register indexes, reset values, phase codes and the seven-segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsq_pkg;

  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned LAMP_W  = 12;
  localparam int unsigned WORDS_W = 48;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_GREEN_HOLD   = 3'd0,
    REG_YELLOW_HOLD  = 3'd1,
    REG_DIGIT_STEP   = 3'd2,
    REG_COUNT_START  = 3'd3,
    REG_GREEN_WORDS  = 3'd4,
    REG_YELLOW_WORDS = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PHASE_GREEN     = 2'd0,
    PHASE_COUNTDOWN = 2'd1,
    PHASE_YELLOW    = 2'd2
  } phase_t;

  localparam logic [HOLD_W-1:0]  GREEN_HOLD_RST   = 16'd15000;
  localparam logic [HOLD_W-1:0]  YELLOW_HOLD_RST  = 16'd5000;
  localparam logic [HOLD_W-1:0]  DIGIT_STEP_RST   = 16'd2160;
  localparam logic [DIGIT_W-1:0] COUNT_START_RST  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX        = 4'd9;
  localparam logic [WORDS_W-1:0] GREEN_WORDS_RST  = 48'd145767048548940;
  localparam logic [WORDS_W-1:0] YELLOW_WORDS_RST = 48'd40288020632145;
  localparam logic [SEG_W-1:0]   SEG_ZERO         = 7'd126;

  typedef struct packed {
    logic [HOLD_W-1:0]  green_hold;
    logic [HOLD_W-1:0]  yellow_hold;
    logic [HOLD_W-1:0]  digit_step;
    logic [DIGIT_W-1:0] count_start;
    logic [WORDS_W-1:0] green_words;
    logic [WORDS_W-1:0] yellow_words;
  } cfg_t;

  typedef struct packed {
    logic [LAMP_W-1:0]          lamps;
    logic [1:0]                 street;
    logic [1:0]                 phase;
    logic [3:0][SEG_W-1:0]      seg;
  } res_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 7'd126;
      4'd1:    code = 7'd48;
      4'd2:    code = 7'd109;
      4'd3:    code = 7'd121;
      4'd4:    code = 7'd51;
      4'd5:    code = 7'd91;
      4'd6:    code = 7'd95;
      4'd7:    code = 7'd112;
      4'd8:    code = 7'd127;
      4'd9:    code = 7'd123;
      default: code = SEG_ZERO;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tlsq_regs.sv @@
// ----------------------------------------------------------------------------
// tlsq_regs: configuration register file
// Holds hold times, countdown start and packed lamp words; writes by index.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsq_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [tlsq_pkg::IDX_W-1:0]        wr_index,
  input  wire logic [tlsq_pkg::WORDS_W-1:0]      wr_data,
  output tlsq_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_hold   <= tlsq_pkg::GREEN_HOLD_RST;
      cfg.yellow_hold  <= tlsq_pkg::YELLOW_HOLD_RST;
      cfg.digit_step   <= tlsq_pkg::DIGIT_STEP_RST;
      cfg.count_start  <= tlsq_pkg::COUNT_START_RST;
      cfg.green_words  <= tlsq_pkg::GREEN_WORDS_RST;
      cfg.yellow_words <= tlsq_pkg::YELLOW_WORDS_RST;
    end else if (wr_en) begin
      case (wr_index)
        tlsq_pkg::REG_GREEN_HOLD:   cfg.green_hold   <= wr_data[tlsq_pkg::HOLD_W-1:0];
        tlsq_pkg::REG_YELLOW_HOLD:  cfg.yellow_hold  <= wr_data[tlsq_pkg::HOLD_W-1:0];
        tlsq_pkg::REG_DIGIT_STEP:   cfg.digit_step   <= wr_data[tlsq_pkg::HOLD_W-1:0];
        tlsq_pkg::REG_COUNT_START:  cfg.count_start  <= wr_data[tlsq_pkg::DIGIT_W-1:0];
        tlsq_pkg::REG_GREEN_WORDS:  cfg.green_words  <= wr_data;
        tlsq_pkg::REG_YELLOW_WORDS: cfg.yellow_words <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/tlsq_core.sv @@
// ----------------------------------------------------------------------------
// tlsq_core: street and phase sequencer
// Steps the millisecond counter, phase, street and countdown digit on ticked
// requests and forms the lamp word and display codes of the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsq_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step_en,
  input  wire logic           tick,
  input  wire tlsq_pkg::cfg_t cfg,
  output tlsq_pkg::res_t      res
);

  logic [1:0]                       street;
  logic [1:0]                       street_next;
  tlsq_pkg::phase_t                 phase;
  tlsq_pkg::phase_t                 phase_next;
  logic [tlsq_pkg::HOLD_W-1:0]      ms_count;
  logic [tlsq_pkg::HOLD_W-1:0]      ms_count_next;
  logic [tlsq_pkg::HOLD_W-1:0]      ms_inc;
  logic [tlsq_pkg::DIGIT_W-1:0]     digit;
  logic [tlsq_pkg::DIGIT_W-1:0]     digit_next;
  logic [tlsq_pkg::DIGIT_W-1:0]     start_digit;
  logic [tlsq_pkg::WORDS_W-1:0]     word;

  assign start_digit = (cfg.count_start > tlsq_pkg::DIGIT_MAX) ? tlsq_pkg::DIGIT_MAX
                                                               : cfg.count_start;
  assign ms_inc = ms_count + 16'd1;

  always_comb begin
    street_next   = street;
    phase_next    = phase;
    ms_count_next = ms_count;
    digit_next    = digit;
    if (tick) begin
      ms_count_next = ms_inc;
      case (phase)
        tlsq_pkg::PHASE_GREEN: begin
          if (ms_inc >= cfg.green_hold) begin
            ms_count_next = '0;
            phase_next    = tlsq_pkg::PHASE_COUNTDOWN;
            digit_next    = start_digit;
          end
        end
        tlsq_pkg::PHASE_COUNTDOWN: begin
          if (ms_inc >= cfg.digit_step) begin
            ms_count_next = '0;
            if (digit == '0) begin
              phase_next = tlsq_pkg::PHASE_YELLOW;
            end else begin
              digit_next = digit - 4'd1;
            end
          end
        end
        default: begin
          if (ms_inc >= cfg.yellow_hold) begin
            ms_count_next = '0;
            phase_next    = tlsq_pkg::PHASE_GREEN;
            street_next   = street + 2'd1;
            digit_next    = start_digit;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      street   <= '0;
      phase    <= tlsq_pkg::PHASE_GREEN;
      ms_count <= '0;
      digit    <= tlsq_pkg::COUNT_START_RST;
    end else if (step_en) begin
      street   <= street_next;
      phase    <= phase_next;
      ms_count <= ms_count_next;
      digit    <= digit_next;
    end
  end

  always_comb begin
    word = (phase_next == tlsq_pkg::PHASE_GREEN || phase_next == tlsq_pkg::PHASE_COUNTDOWN)
         ? cfg.green_words : cfg.yellow_words;
    case (street_next)
      2'd0:    res.lamps = word[11:0];
      2'd1:    res.lamps = word[23:12];
      2'd2:    res.lamps = word[35:24];
      default: res.lamps = word[47:36];
    endcase
    res.street = street_next;
    res.phase  = (phase_next == tlsq_pkg::PHASE_GREEN ||
                  phase_next == tlsq_pkg::PHASE_COUNTDOWN) ? phase_next
                                                           : tlsq_pkg::PHASE_YELLOW;
    for (int k = 0; k < 4; k++) begin
      if (phase_next == tlsq_pkg::PHASE_COUNTDOWN && street_next == 2'(k) &&
          digit_next <= tlsq_pkg::DIGIT_MAX) begin
        res.seg[k] = tlsq_pkg::seg_code(digit_next);
      end else begin
        res.seg[k] = tlsq_pkg::SEG_ZERO;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/four_way_traffic_light_sequencer.sv @@
// ----------------------------------------------------------------------------
// four_way_traffic_light_sequencer: four-street lamp and countdown sequencer
// Path: an accepted request waits in the input register; its result is then captured in the result register.
// Throughput: one request per cycle unless out_stall holds the result; the
// input register and the result register each pass one request a cycle.
// Reset: clears both stages, returns to street 1 green with the counter at
// zero and digit 5, and loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module four_way_traffic_light_sequencer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              tick,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tlsq_pkg::LAMP_W-1:0]            lamps,
  output logic [1:0]                             active_street,
  output logic [1:0]                             phase_now,
  output logic [tlsq_pkg::SEG_W-1:0]             seg_street1,
  output logic [tlsq_pkg::SEG_W-1:0]             seg_street2,
  output logic [tlsq_pkg::SEG_W-1:0]             seg_street3,
  output logic [tlsq_pkg::SEG_W-1:0]             seg_street4,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tlsq_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [tlsq_pkg::WORDS_W-1:0]      cfg_data
);

  tlsq_pkg::cfg_t  cfg;
  tlsq_pkg::res_t  res;
  tlsq_pkg::res_t  res_q;
  logic            s1_valid;
  logic            s1_tick;
  logic            out_ready;
  logic            s1_ready;
  logic            fire;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid || !out_stall;
  assign fire      = s1_valid && out_ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;

  tlsq_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlsq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (fire),
    .tick    (s1_tick),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= fire;
      end
    end
    if (s1_ready && in_valid) begin
      s1_tick <= tick;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign lamps         = res_q.lamps;
  assign active_street = res_q.street;
  assign phase_now     = res_q.phase;
  assign seg_street1   = res_q.seg[0];
  assign seg_street2   = res_q.seg[1];
  assign seg_street3   = res_q.seg[2];
  assign seg_street4   = res_q.seg[3];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage is free");

  a_one_display_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({seg_street1 != tlsq_pkg::SEG_ZERO,
                              seg_street2 != tlsq_pkg::SEG_ZERO,
                              seg_street3 != tlsq_pkg::SEG_ZERO,
                              seg_street4 != tlsq_pkg::SEG_ZERO}) <= 1)
    else $error("more than one display counting");

  a_digits_only_in_countdown: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase_now != tlsq_pkg::PHASE_COUNTDOWN) |->
      (seg_street1 == tlsq_pkg::SEG_ZERO && seg_street2 == tlsq_pkg::SEG_ZERO &&
       seg_street3 == tlsq_pkg::SEG_ZERO && seg_street4 == tlsq_pkg::SEG_ZERO))
    else $error("display lit outside countdown");

endmodule

`default_nettype wire
